FILE: sv/qpd_pkg.sv
package qpd_pkg;

  // internal values are signed Q16.16 in 64 bits, saturated to +-(2^62 - 1)
  localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LIM_W = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  // product of a 63-bit magnitude and a 33-bit magnitude plus rounding
  localparam int MD_PW = 97;
  localparam int MD_CW = $clog2(MD_PW + 1);

  localparam int CMDQ_DEPTH = 2;

  // power-of-two divisors, as right shifts
  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_HALF = 6'd1;
  localparam logic [5:0] SH_Q16  = 6'd16;
  localparam logic [5:0] SH_Q32  = 6'd32;

  localparam logic signed [33:0] Q16_ONE  = 34'sd65536;
  localparam logic signed [33:0] Q32_ONE  = 34'sh1_0000_0000;
  localparam logic signed [33:0] UNIT     = 34'sd1;
  localparam logic signed [33:0] D1_LEAD  = 34'sd5;
  localparam logic signed [33:0] D2_LEAD  = 34'sd20;

  // rows: coefficients 3, 4, 5; columns: D, P0, P1, Q0, Q1
  localparam logic signed [7:0] LIN_COEF [3][5] = '{
    '{ 8'sd20, -8'sd12,  -8'sd8, -8'sd3,  8'sd1},
    '{-8'sd30,  8'sd16,  8'sd14,  8'sd3, -8'sd2},
    '{ 8'sd12,  -8'sd6,  -8'sd6, -8'sd1,  8'sd1}
  };

  // i*(i-1) for the second-derivative Horner chain
  localparam logic signed [7:0] D2_COEF [5] = '{8'sd0, 8'sd0, 8'sd2, 8'sd6, 8'sd12};

  typedef enum logic {CMD_ERR, CMD_SEG} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        path_end;
    logic [31:0] s0;
    logic [31:0] l0;
    logic [31:0] sl0;
    logic [31:0] c0;
    logic [31:0] s1;
    logic [31:0] l1;
    logic [31:0] sl1;
    logic [31:0] c1;
  } cmd_t;

  // round(a*b/d), d either 2^sh or the divisor d
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [33:0] b;
    logic               div;
    logic [5:0]         sh;
    logic [32:0]        d;
    logic               rnd;
  } md_op_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_MLO, MD_MHI, MD_RND, MD_DIV, MD_FIN, MD_DONE
  } md_state_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_P0, BK_P1, BK_C0A, BK_C0B, BK_C1A, BK_C1B, BK_LIN,
    BK_U, BK_T, BK_D1I, BK_D2I, BK_HV, BK_HD1A, BK_HD1B, BK_HD2A, BK_HD2B,
    BK_OL, BK_OSL, BK_OCA, BK_OCB, BK_EMIT, BK_LAST, BK_ERR
  } bk_state_t;

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return 64'($signed(v));
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > SAT_LIM_W) begin
      return SAT_LIM;
    end else if (s < -SAT_LIM_W) begin
      return -SAT_LIM;
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] out32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic md_op_t make_op(input logic signed [63:0] a,
                                     input logic signed [33:0] b,
                                     input logic div, input logic [5:0] sh,
                                     input logic [32:0] d, input logic rnd);
    md_op_t o;
    o.a   = a;
    o.b   = b;
    o.div = div;
    o.sh  = sh;
    o.d   = d;
    o.rnd = rnd;
    return o;
  endfunction

endpackage

FILE: sv/qpd_if.sv
interface qpd_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        point_s;
  logic signed [31:0] point_l;
  logic signed [31:0] point_slope;
  logic signed [31:0] point_curv;
  logic               path_end;

  modport source(output valid, point_s, point_l, point_slope, point_curv, path_end,
                 input ready);
  modport sink(input valid, point_s, point_l, point_slope, point_curv, path_end,
               output ready);
endinterface

interface qpd_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        out_s;
  logic signed [31:0] out_l;
  logic signed [31:0] out_slope;
  logic signed [31:0] out_curv;
  logic               status;
  logic               run_last;

  modport source(output valid, out_s, out_l, out_slope, out_curv, status, run_last,
                 input ready);
  modport sink(input valid, out_s, out_l, out_slope, out_curv, status, run_last,
               output ready);
endinterface

FILE: sv/quintic_path_densifier.sv
// Quintic path densifier.
// in_ch takes path points (station, offset, slope, curvature, path_end); out_ch
// gives interpolated points with status and run_last. Both are valid/ready,
// an item moves on a cycle where valid and ready are both high.
// segment_count sits at APB address 0 (reads back; 0 acts as 1, values above
// MAX_SEGMENT_POINTS are clipped).
// The front tracks the previous point, drops rejected paths and queues one
// command per segment or error in a two-entry queue; in_ch stalls only when
// that queue is full. The back runs each command on one shared multiply/divide
// unit: a power-of-two scale is a right shift, a true division gives one
// quotient bit per cycle over a 97-bit product.
// A segment gives n interpolated points; after a path's last segment the
// pass-through end point follows, and an error gives a single result.
// A stalled out_ch holds its output register and the back waits on it; the
// front keeps taking items until the queue fills.
// Reset (rst, synchronous) empties the queue, forgets any previous point or
// rejected path, and sets segment_count to 4.
module quintic_path_densifier import qpd_pkg::*; #(
  parameter int MAX_SEGMENT_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  qpd_in_if.sink      in_ch,
  qpd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] segment_count;
  logic       q_full;
  logic       push;
  cmd_t       push_data;
  logic       pop;
  logic       q_valid;
  cmd_t       q_data;
  md_op_t     md_op;
  logic       md_start;
  logic       md_done;
  logic signed [63:0] md_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'h0, segment_count} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 6'd4;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      segment_count <= pwdata[5:0];
    end
  end

  qpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  qpd_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  qpd_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .op    (md_op),
    .done  (md_done),
    .res   (md_res)
  );

  qpd_back #(
    .MAX_PTS (MAX_SEGMENT_POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .segment_count (segment_count),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .md_op         (md_op),
    .md_start      (md_start),
    .md_done       (md_done),
    .md_res        (md_res),
    .out_ch        (out_ch)
  );

endmodule

FILE: sv/qpd_front.sv
module qpd_front import qpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  qpd_in_if.sink in_ch,
  input  logic q_full,
  output logic push,
  output cmd_t push_data
);

  logic [31:0] prev_s;
  logic [31:0] prev_l;
  logic [31:0] prev_sl;
  logic [31:0] prev_c;
  logic        have_prev;
  logic        failed;
  logic        accept;
  logic        bad_step;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign bad_step    = !have_prev || (in_ch.point_s <= prev_s);

  always_comb begin
    push               = 1'b0;
    push_data.kind     = CMD_SEG;
    push_data.path_end = in_ch.path_end;
    push_data.s0       = prev_s;
    push_data.l0       = prev_l;
    push_data.sl0      = prev_sl;
    push_data.c0       = prev_c;
    push_data.s1       = in_ch.point_s;
    push_data.l1       = in_ch.point_l;
    push_data.sl1      = in_ch.point_slope;
    push_data.c1       = in_ch.point_curv;
    if (accept && !failed) begin
      if (bad_step) begin
        if (have_prev || in_ch.path_end) begin
          push           = 1'b1;
          push_data.kind = CMD_ERR;
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      failed    <= 1'b0;
    end else if (accept) begin
      if (failed) begin
        if (in_ch.path_end) begin
          failed <= 1'b0;
        end
      end else if (bad_step) begin
        if (have_prev || in_ch.path_end) begin
          have_prev <= 1'b0;
          failed    <= !in_ch.path_end;
        end else begin
          have_prev <= 1'b1;
        end
      end else begin
        have_prev <= !in_ch.path_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !failed && (have_prev ? !bad_step : !in_ch.path_end)) begin
      prev_s  <= in_ch.point_s;
      prev_l  <= in_ch.point_l;
      prev_sl <= in_ch.point_slope;
      prev_c  <= in_ch.point_curv;
    end
  end

endmodule

FILE: sv/qpd_cmdq.sv
module qpd_cmdq import qpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_data
);

  localparam int AW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem [CMDQ_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(CMDQ_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/qpd_muldiv.sv
module qpd_muldiv import qpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  md_op_t             op,
  output logic               done,
  output logic signed [63:0] res
);

  md_state_t        state;
  md_state_t        state_next;
  logic             neg;
  logic [63:0]      ua;
  logic [32:0]      ub;
  logic             div;
  logic [5:0]       sh;
  logic [32:0]      dv;
  logic             rnd;
  logic [MD_PW-1:0] acc;
  logic [32:0]      rem;
  logic [MD_CW-1:0] cnt;

  logic [64:0]      pp;
  logic [33:0]      rem_sh;
  logic             qbit;
  logic [MD_PW-1:0] rnd_add;
  logic [MD_PW-1:0] quo;
  logic [62:0]      mag;
  logic [33:0]      b_abs;

  // one 32x33 multiplier, used for the low then the high half of |a|
  assign pp     = 65'(state == MD_MHI ? ua[63:32] : ua[31:0]) * 65'(ub);
  assign rem_sh = {rem, acc[MD_PW-1]};
  assign qbit   = (rem_sh >= {1'b0, dv});
  assign done   = (state == MD_DONE);
  assign b_abs  = op.b[33] ? 34'(-op.b) : 34'(op.b);

  always_comb begin
    if (!rnd) begin
      rnd_add = '0;
    end else if (div) begin
      rnd_add = MD_PW'(dv >> 1);
    end else if (sh == SH_NONE) begin
      rnd_add = '0;
    end else begin
      rnd_add = MD_PW'(1) << (sh - 6'd1);
    end
    quo = div ? acc : (acc >> sh);
    mag = (quo > MD_PW'(SAT_LIM)) ? SAT_LIM[62:0] : quo[62:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (start) state_next = MD_MLO;
      MD_MLO:  state_next = MD_MHI;
      MD_MHI:  state_next = MD_RND;
      MD_RND:  state_next = div ? MD_DIV : MD_FIN;
      MD_DIV:  if (cnt == MD_CW'(MD_PW - 1)) state_next = MD_FIN;
      MD_FIN:  state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          neg <= op.a[63] ^ op.b[33];
          ua  <= op.a[63] ? 64'(-op.a) : 64'(op.a);
          ub  <= b_abs[32:0];
          div <= op.div;
          sh  <= op.sh;
          dv  <= op.d;
          rnd <= op.rnd;
          rem <= '0;
          cnt <= '0;
        end
      end
      MD_MLO: acc <= MD_PW'(pp);
      MD_MHI: acc <= acc + {pp, 32'h0};
      MD_RND: acc <= acc + rnd_add;
      MD_DIV: begin
        // restoring division, quotient shifts in behind the dividend
        rem <= qbit ? 33'(rem_sh - {1'b0, dv}) : rem_sh[32:0];
        acc <= {acc[MD_PW-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      MD_FIN: res <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      default: ;
    endcase
  end

endmodule

FILE: sv/qpd_back.sv
module qpd_back import qpd_pkg::*; #(
  parameter int MAX_PTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         segment_count,
  input  logic               q_valid,
  input  cmd_t               q_data,
  output logic               pop,
  output md_op_t             md_op,
  output logic               md_start,
  input  logic               md_done,
  input  logic signed [63:0] md_res,
  qpd_out_if.source          out_ch
);

  localparam int NW = $clog2(MAX_PTS + 1);

  bk_state_t          state;
  bk_state_t          state_next;
  logic               issued;
  cmd_t               cmd;
  logic [31:0]        h;
  logic [NW-1:0]      n;
  logic [NW-1:0]      j;
  logic [31:0]        u;
  logic [31:0]        t;
  logic signed [63:0] k [6];
  logic signed [63:0] dd;
  logic signed [63:0] p0;
  logic signed [63:0] p1;
  logic signed [63:0] q0;
  logic signed [63:0] q1;
  logic signed [63:0] x;
  logic signed [63:0] acc;
  logic signed [63:0] v;
  logic signed [63:0] d1;
  logic signed [63:0] d2;
  logic [1:0]         row;
  logic [2:0]         term;
  logic [2:0]         hi;
  logic [31:0]        res_l;
  logic [31:0]        res_sl;
  logic               out_valid;
  logic [31:0]        o_s;
  logic [31:0]        o_l;
  logic [31:0]        o_sl;
  logic [31:0]        o_cv;
  logic               o_status;
  logic               o_last;

  logic               is_op;
  logic               out_free;
  logic               out_load;
  logic signed [63:0] lin_a;
  logic signed [63:0] lin_sum;
  logic [33:0]        hb;
  logic [NW-1:0]      n_eff;

  assign out_free = !out_valid || out_ch.ready;
  assign hb       = {2'b00, h};
  assign lin_sum  = sadd(acc, md_res);
  assign md_start = is_op && !issued;

  always_comb begin
    if (segment_count == 6'd0) begin
      n_eff = NW'(1);
    end else if (segment_count > 6'(MAX_PTS)) begin
      n_eff = NW'(MAX_PTS);
    end else begin
      n_eff = NW'(segment_count);
    end
  end

  always_comb begin
    case (term)
      3'd0:    lin_a = dd;
      3'd1:    lin_a = p0;
      3'd2:    lin_a = p1;
      3'd3:    lin_a = q0;
      default: lin_a = q1;
    endcase
  end

  always_comb begin
    state_next = state;
    is_op      = 1'b1;
    pop        = 1'b0;
    out_load   = 1'b0;
    md_op      = make_op(v, UNIT, 1'b0, SH_NONE, '0, 1'b1);
    unique case (state)
      BK_IDLE: begin
        is_op = 1'b0;
        if (q_valid) begin
          pop        = 1'b1;
          state_next = (q_data.kind == CMD_ERR) ? BK_ERR : BK_P0;
        end
      end
      BK_P0: begin
        md_op = make_op(sx32(cmd.sl0), hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_P1;
      end
      BK_P1: begin
        md_op = make_op(sx32(cmd.sl1), hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_C0A;
      end
      BK_C0A: begin
        md_op = make_op(sx32(cmd.c0), hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_C0B;
      end
      BK_C0B: begin
        md_op = make_op(x, hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_C1A;
      end
      BK_C1A: begin
        md_op = make_op(sx32(cmd.c1), hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_C1B;
      end
      BK_C1B: begin
        md_op = make_op(x, hb, 1'b0, SH_Q16, '0, 1'b1);
        if (md_done) state_next = BK_LIN;
      end
      BK_LIN: begin
        md_op = make_op(lin_a, 34'(LIN_COEF[row][term]), 1'b0, SH_NONE, '0, 1'b1);
        if (md_done && term == 3'd4 && row == 2'd2) state_next = BK_U;
      end
      BK_U: begin
        // station offset: floor(j*h/n)
        md_op = make_op(64'(j), hb, 1'b1, SH_NONE, 33'(n), 1'b0);
        if (md_done) state_next = BK_T;
      end
      BK_T: begin
        // t = floor(u * 2^32 / h), Q0.32
        md_op = make_op({32'h0, u}, Q32_ONE, 1'b1, SH_NONE, {1'b0, h}, 1'b0);
        if (md_done) state_next = BK_D1I;
      end
      BK_D1I: begin
        md_op = make_op(k[5], D1_LEAD, 1'b0, SH_NONE, '0, 1'b1);
        if (md_done) state_next = BK_D2I;
      end
      BK_D2I: begin
        md_op = make_op(k[5], D2_LEAD, 1'b0, SH_NONE, '0, 1'b1);
        if (md_done) state_next = BK_HV;
      end
      BK_HV: begin
        md_op = make_op(v, {2'b00, t}, 1'b0, SH_Q32, '0, 1'b1);
        if (md_done) state_next = (hi != 3'd0) ? BK_HD1A : BK_OL;
      end
      BK_HD1A: begin
        md_op = make_op(d1, {2'b00, t}, 1'b0, SH_Q32, '0, 1'b1);
        if (md_done) state_next = BK_HD1B;
      end
      BK_HD1B: begin
        md_op = make_op(k[hi], {31'h0, hi}, 1'b0, SH_NONE, '0, 1'b1);
        if (md_done) state_next = (hi >= 3'd2) ? BK_HD2A : BK_HV;
      end
      BK_HD2A: begin
        md_op = make_op(d2, {2'b00, t}, 1'b0, SH_Q32, '0, 1'b1);
        if (md_done) state_next = BK_HD2B;
      end
      BK_HD2B: begin
        md_op = make_op(k[hi], 34'(D2_COEF[hi]), 1'b0, SH_NONE, '0, 1'b1);
        if (md_done) state_next = BK_HV;
      end
      BK_OL: begin
        md_op = make_op(v, UNIT, 1'b0, SH_HALF, '0, 1'b1);
        if (md_done) state_next = BK_OSL;
      end
      BK_OSL: begin
        md_op = make_op(d1, Q16_ONE, 1'b1, SH_NONE, {h, 1'b0}, 1'b1);
        if (md_done) state_next = BK_OCA;
      end
      BK_OCA: begin
        md_op = make_op(d2, Q16_ONE, 1'b1, SH_NONE, {1'b0, h}, 1'b1);
        if (md_done) state_next = BK_OCB;
      end
      BK_OCB: begin
        md_op = make_op(x, Q16_ONE, 1'b1, SH_NONE, {h, 1'b0}, 1'b1);
        if (md_done) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        is_op = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          if (j == n - 1'b1) begin
            state_next = cmd.path_end ? BK_LAST : BK_IDLE;
          end else begin
            state_next = BK_U;
          end
        end
      end
      BK_LAST, BK_ERR: begin
        is_op = 1'b0;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        is_op      = 1'b0;
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (md_done) begin
        issued <= 1'b0;
      end else if (md_start) begin
        issued <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          cmd  <= q_data;
          h    <= q_data.s1 - q_data.s0;
          dd   <= sx32(q_data.l1) - sx32(q_data.l0);
          k[0] <= sx32(q_data.l0) <<< 1;
          n    <= n_eff;
          j    <= '0;
          row  <= '0;
          term <= '0;
          acc  <= '0;
        end
      end
      BK_P0: begin
        if (md_done) begin
          p0   <= md_res;
          k[1] <= md_res <<< 1;
        end
      end
      BK_P1:  if (md_done) p1 <= md_res;
      BK_C0A: if (md_done) x <= md_res;
      BK_C0B: begin
        if (md_done) begin
          q0   <= md_res;
          k[2] <= md_res;
        end
      end
      BK_C1A: if (md_done) x <= md_res;
      BK_C1B: if (md_done) q1 <= md_res;
      BK_LIN: begin
        if (md_done) begin
          if (term == 3'd4) begin
            k[3'(row) + 3'd3] <= lin_sum;
            acc  <= '0;
            term <= '0;
            row  <= row + 1'b1;
          end else begin
            acc  <= lin_sum;
            term <= term + 1'b1;
          end
        end
      end
      BK_U: if (md_done) u <= md_res[31:0];
      BK_T: if (md_done) t <= md_res[31:0];
      BK_D1I: begin
        if (md_done) begin
          d1 <= md_res;
          v  <= k[5];
        end
      end
      BK_D2I: begin
        if (md_done) begin
          d2 <= md_res;
          hi <= 3'd4;
        end
      end
      BK_HV:   if (md_done) v <= sadd(md_res, k[hi]);
      BK_HD1A: if (md_done) acc <= md_res;
      BK_HD1B: begin
        if (md_done) begin
          d1 <= lin_sum;
          if (hi < 3'd2) hi <= hi - 1'b1;
        end
      end
      BK_HD2A: if (md_done) acc <= md_res;
      BK_HD2B: begin
        if (md_done) begin
          d2 <= lin_sum;
          hi <= hi - 1'b1;
        end
      end
      BK_OL:  if (md_done) res_l <= out32(md_res);
      BK_OSL: if (md_done) res_sl <= out32(md_res);
      BK_OCA: if (md_done) x <= md_res;
      // x holds the curvature until the point goes out
      BK_OCB: if (md_done) x <= md_res;
      BK_EMIT: begin
        if (out_free) begin
          j        <= j + 1'b1;
          o_s      <= cmd.s0 + u;
          o_l      <= res_l;
          o_sl     <= res_sl;
          o_cv     <= out32(x);
          o_status <= 1'b0;
          o_last   <= 1'b0;
        end
      end
      BK_LAST: begin
        if (out_free) begin
          o_s      <= cmd.s1;
          o_l      <= cmd.l1;
          o_sl     <= cmd.sl1;
          o_cv     <= cmd.c1;
          o_status <= 1'b0;
          o_last   <= 1'b1;
        end
      end
      BK_ERR: begin
        if (out_free) begin
          o_s      <= '0;
          o_l      <= '0;
          o_sl     <= '0;
          o_cv     <= '0;
          o_status <= 1'b1;
          o_last   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_s     = o_s;
  assign out_ch.out_l     = o_l;
  assign out_ch.out_slope = o_sl;
  assign out_ch.out_curv  = o_cv;
  assign out_ch.status    = o_status;
  assign out_ch.run_last  = o_last;

endmodule

FILE: sv/qpd_checker.sv
module qpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_s,
  input logic [31:0] out_l,
  input logic        out_status,
  input logic        out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_run_last && out_s == 32'h0 && out_l == 32'h0)
    else $error("rejected path item malformed");

endmodule

bind quintic_path_densifier qpd_checker u_qpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_s        (out_ch.out_s),
  .out_l        (out_ch.out_l),
  .out_status   (out_ch.status),
  .out_run_last (out_ch.run_last)
);

FILE: dv/quintic_path_densifier_checker.sv
module quintic_path_densifier_checker import qpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qpd_in_if           in_ch,
  qpd_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);

  localparam logic [2:0] ADDR_SEG_COUNT = 3'd0;
  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_REJECT = 1'b1;
  localparam longint SAT = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE16 = 64'd65536;
  localparam logic [63:0] ONE32 = 64'h1_0000_0000;

  typedef struct {
    logic [31:0] s;
    logic [31:0] l;
    logic [31:0] sl;
    logic [31:0] c;
    logic        status;
    logic        last;
  } dense_pt_t;

  dense_pt_t   expected_pts[$];
  logic [31:0] last_s, last_l, last_sl, last_c;
  logic        have_last, dropping;
  logic [5:0]  seg_count;

  // round(a*b/d), halves away from zero, clamped to the internal range
  function automatic longint scale_round(longint a, longint b, logic [63:0] d);
    logic         neg;
    logic [63:0]  ua, ub, m;
    logic [127:0] prod, quo;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = 128'(ua) * 128'(ub) + 128'(d >> 1);
    quo = prod / 128'(d);
    m = (quo > 128'(SAT)) ? 64'(SAT) : quo[63:0];
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SAT)) return SAT;
    if (s < -65'(SAT)) return -SAT;
    return longint'(s[63:0]);
  endfunction

  function automatic logic [31:0] to_q32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint coef_mix(longint dd, p0, p1, q0, q1,
                                      longint cd, cp0, cp1, cq0, cq1);
    longint s;
    s = scale_round(dd, cd, 1);
    s = clamp_add(s, scale_round(p0, cp0, 1));
    s = clamp_add(s, scale_round(p1, cp1, 1));
    s = clamp_add(s, scale_round(q0, cq0, 1));
    return clamp_add(s, scale_round(q1, cq1, 1));
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic push_pt(logic [31:0] s, l, sl, c, logic st, logic lst);
    dense_pt_t p;
    p.s = s; p.l = l; p.sl = sl; p.c = c; p.status = st; p.last = lst;
    expected_pts.insert(expected_pts.size(), p);
  endtask

  task automatic densify(logic [31:0] s, l, sl, c, logic pend);
    logic [63:0] h, n, u, jj;
    longint      dd, p0, p1, q0, q1, t, v, d1, d2;
    longint      kc[6];
    if (dropping) begin
      if (pend) dropping = 1'b0;
      return;
    end
    if (!have_last || s <= last_s) begin
      if (have_last || pend) begin
        push_pt(0, 0, 0, 0, STAT_REJECT, 1'b1);
        have_last = 1'b0;
        dropping = !pend;
      end else begin
        last_s = s; last_l = l; last_sl = sl; last_c = c;
        have_last = 1'b1;
      end
      return;
    end
    h = 64'(s) - 64'(last_s);
    n = (seg_count == 0) ? 1 : (seg_count > 32) ? 32 : 64'(seg_count);
    dd = sx(l) - sx(last_l);
    p0 = scale_round(sx(last_sl), longint'(h), ONE16);
    p1 = scale_round(sx(sl), longint'(h), ONE16);
    q0 = scale_round(scale_round(sx(last_c), longint'(h), ONE16), longint'(h), ONE16);
    q1 = scale_round(scale_round(sx(c), longint'(h), ONE16), longint'(h), ONE16);
    kc[0] = 2 * sx(last_l);
    kc[1] = scale_round(p0, 2, 1);
    kc[2] = q0;
    kc[3] = coef_mix(dd, p0, p1, q0, q1, 20, -12, -8, -3, 1);
    kc[4] = coef_mix(dd, p0, p1, q0, q1, -30, 16, 14, 3, -2);
    kc[5] = coef_mix(dd, p0, p1, q0, q1, 12, -6, -6, -1, 1);
    for (jj = 0; jj < n; jj++) begin
      u = jj * h / n;
      t = longint'((u << 32) / h);
      v = kc[5];
      d1 = scale_round(kc[5], 5, 1);
      d2 = scale_round(kc[5], 20, 1);
      for (int i = 4; i >= 0; i--) begin
        v = clamp_add(scale_round(v, t, ONE32), kc[i]);
        if (i >= 1) d1 = clamp_add(scale_round(d1, t, ONE32), scale_round(kc[i], i, 1));
        if (i >= 2)
          d2 = clamp_add(scale_round(d2, t, ONE32), scale_round(kc[i], i * (i - 1), 1));
      end
      push_pt(last_s + u[31:0], to_q32(scale_round(v, 1, 2)),
              to_q32(scale_round(d1, 65536, 2 * h)),
              to_q32(scale_round(scale_round(d2, 65536, h), 65536, 2 * h)),
              STAT_OK, 1'b0);
    end
    last_s = s; last_l = l; last_sl = sl; last_c = c;
    if (pend) begin
      push_pt(s, l, sl, c, STAT_OK, 1'b1);
      have_last = 1'b0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    dense_pt_t e;
    if (rst) begin
      expected_pts.delete();
      have_last = 1'b0;
      dropping = 1'b0;
      last_s = '0; last_l = '0; last_sl = '0; last_c = '0;
      seg_count = 6'd4;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_SEG_COUNT)
        seg_count = pwdata[5:0];
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          report("unexpected item station", out_ch.out_s, 32'h0);
        end else begin
          e = expected_pts.pop_front();
          if (out_ch.out_s !== e.s) report("out_s", out_ch.out_s, e.s);
          if (out_ch.out_l !== e.l) report("out_l", out_ch.out_l, e.l);
          if (out_ch.out_slope !== e.sl) report("out_slope", out_ch.out_slope, e.sl);
          if (out_ch.out_curv !== e.c) report("out_curv", out_ch.out_curv, e.c);
          if (out_ch.status !== e.status) report("status", 32'(out_ch.status), 32'(e.status));
          if (out_ch.run_last !== e.last)
            report("run_last", 32'(out_ch.run_last), 32'(e.last));
        end
      end
      if (in_ch.valid && in_ch.ready)
        densify(in_ch.point_s, in_ch.point_l, in_ch.point_slope, in_ch.point_curv,
                in_ch.path_end);
    end
    pending = expected_pts.size();
  end

endmodule

FILE: dv/quintic_path_densifier_test.sv
module quintic_path_densifier_test;
  import qpd_pkg::*;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fails, pending;
  bit          out_steady;

  localparam logic [2:0] ADDR_SEG_COUNT = 3'd0;

  qpd_in_if  in_ch();
  qpd_out_if out_ch();

  quintic_path_densifier uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  quintic_path_densifier_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // output back-pressure: mostly ready, short and occasional long stalls
  initial begin
    int gap;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = out_steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      3: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 255);
      1, 2: return $urandom_range(1, 32'h0010_0000);
      3: return $urandom_range(1, 32'h1000_0000);
      4: return $urandom_range(32'h0001_0000, 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [31:0] s, l, sl, c, logic pend, bit quiet);
    int gap;
    in_ch.point_s <= s;
    in_ch.point_l <= l;
    in_ch.point_slope <= sl;
    in_ch.point_curv <= c;
    in_ch.path_end <= pend;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one path of len points; broken lowers one station inside it, which can make it non-increasing
  task automatic send_path(int len, bit broken, bit quiet);
    logic [31:0] s;
    int          bad;
    s = (len > 4) ? $urandom_range(0, 32'h3FFF_FFFF) : $urandom;
    bad = $urandom_range(1, len - 1);
    for (int k = 0; k < len; k++) begin
      if (k > 0) s = s + pick_step();
      if (broken && k == bad) s = s - $urandom_range(0, 32'h0002_0000);
      send_point(s, pick_value(), pick_value(), pick_value(), k == len - 1, quiet);
    end
  endtask

  // the extra edge lets the checker count the item taken at the last edge
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_seg_count(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_SEG_COUNT; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  int seg_vals[10] = '{0, 63, 1, 2, 3, 32, 6, 1, 4, 5};
  int phase_len[10] = '{15, 4, 70, 70, 60, 4, 25, 50, 90, 20};

  initial begin
    int sent, len, r;
    bit quiet;
    out_steady = 1'b0;
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.point_s <= '0; in_ch.point_l <= '0;
    in_ch.point_slope <= '0; in_ch.point_curv <= '0; in_ch.path_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-point path is rejected
    send_point(32'h100, 32'h1234, 32'h0, 32'h0, 1'b1, 1'b0);
    // extreme fields, tiny then huge segment
    send_point(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    send_point(32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0);
    // repeated station mid-path, then the rest of the path is dropped
    send_point(32'h000A_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h000A_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h000B_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h000C_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    // backward station on the final point
    send_point(32'h0014_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h0013_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    // ordinary path with pass-through end
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_C000, 1'b0, 1'b0);
    send_point(32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 1'b0);
    send_point(32'h0004_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_seg_count(seg_vals[ph]);
      quiet = (ph == 3);
      out_steady = (ph == 3);
      sent = 0;
      while (sent < phase_len[ph]) begin
        r = $urandom_range(0, 9);
        if (seg_vals[ph] > 8 || seg_vals[ph] == 0) len = $urandom_range(2, 3);
        else len = $urandom_range(2, 6);
        if (r < 7) begin
          send_path(len, 1'b0, quiet);
        end else if (r < 9) begin
          send_path(len, 1'b1, quiet);
        end else begin
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            send_point($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1), quiet);
        end
        sent += len;
        if (ph == 4 && sent >= 30 && sent < 30 + len) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end

    in_ch.valid <= 1'b0;
    out_steady = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/qpd_pkg.sv
sv/qpd_if.sv
sv/qpd_front.sv
sv/qpd_cmdq.sv
sv/qpd_muldiv.sv
sv/qpd_back.sv
sv/quintic_path_densifier.sv
sv/qpd_checker.sv
dv/quintic_path_densifier_checker.sv
dv/quintic_path_densifier_test.sv
